/* rtl/core/tcch_pkg.sv */
// Shared types, constants and the arctangent table of the compass heading block.
`default_nettype none
package tcch_pkg;

  // One three-axis sample.
  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } axes_t;

  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [15:0] CDEG_TURN = 16'd36000;
  localparam int unsigned TABLE_LEN = 24;

  // Configuration register indexes.
  localparam logic [2:0] REG_MIN_X = 3'd0;
  localparam logic [2:0] REG_MIN_Y = 3'd1;
  localparam logic [2:0] REG_MIN_Z = 3'd2;
  localparam logic [2:0] REG_MAX_X = 3'd3;
  localparam logic [2:0] REG_MAX_Y = 3'd4;
  localparam logic [2:0] REG_MAX_Z = 3'd5;

  // atan(2^-i) as a binary angle, a full turn being 2^32.
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/tcch_delay.sv */
// Enabled shift line that delays a word through a chain of registers.
`default_nettype none
module tcch_delay #(
  parameter int W     = 16,
  parameter int DEPTH = 1
) (
  input  wire logic         clk,
  input  wire logic         ce,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);
  logic [W-1:0] taps [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (ce) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) taps[i] <= taps[i-1];
    end
  end

  assign q = taps[DEPTH-1];
endmodule
`default_nettype wire

/* rtl/core/tcch_front.sv */
// Hard-iron correction, East cross product and squared acceleration magnitude.
`default_nettype none
module tcch_front (
  input  wire logic                clk,
  input  wire logic                ce,
  input  wire tcch_pkg::axes_t     accel,
  input  wire tcch_pkg::axes_t     mag,
  input  wire tcch_pkg::axes_t     mag_min,
  input  wire tcch_pkg::axes_t     mag_max,
  output tcch_pkg::axes_t          accel1,
  output tcch_pkg::axes_t          accel3,
  output logic signed [34:0]       ex3,
  output logic signed [34:0]       ey3,
  output logic signed [34:0]       ez3,
  output logic        [31:0]       asq3
);
  logic signed [17:0] mx_c, my_c, mz_c;
  logic signed [17:0] mx1, my1, mz1;
  logic signed [33:0] myaz, mzay, mzax, mxaz, mxay, myax;
  logic        [31:0] axsq, aysq, azsq;
  tcch_pkg::axes_t    accel2;

  // Twice the sample minus (min + max) keeps the offset on whole LSBs.
  function automatic logic signed [17:0] hard_iron(input logic signed [15:0] m,
                                                   input logic signed [15:0] lo,
                                                   input logic signed [15:0] hi);
    logic signed [17:0] twice;
    logic signed [17:0] sum;
    twice = {m[15], m, 1'b0};
    sum   = {{2{lo[15]}}, lo} + {{2{hi[15]}}, hi};
    return twice - sum;
  endfunction

  always_comb begin
    mx_c = hard_iron(mag.x, mag_min.x, mag_max.x);
    my_c = hard_iron(mag.y, mag_min.y, mag_max.y);
    mz_c = hard_iron(mag.z, mag_min.z, mag_max.z);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      accel1 <= accel;
      mx1    <= mx_c;
      my1    <= my_c;
      mz1    <= mz_c;
      accel2 <= accel1;
      myaz   <= my1 * accel1.z;
      mzay   <= mz1 * accel1.y;
      mzax   <= mz1 * accel1.x;
      mxaz   <= mx1 * accel1.z;
      mxay   <= mx1 * accel1.y;
      myax   <= my1 * accel1.x;
      axsq   <= 32'(accel1.x * accel1.x);
      aysq   <= 32'(accel1.y * accel1.y);
      azsq   <= 32'(accel1.z * accel1.z);
      accel3 <= accel2;
      ex3    <= {myaz[33], myaz} - {mzay[33], mzay};
      ey3    <= {mzax[33], mzax} - {mxaz[33], mxaz};
      ez3    <= {mxay[33], mxay} - {myax[33], myax};
      asq3   <= axsq + aysq + azsq;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/tcch_sqrt.sv */
// Pipelined digit-by-digit square root of a 32-bit value, rounded to nearest.
`default_nettype none
module tcch_sqrt (
  input  wire logic        clk,
  input  wire logic        ce,
  input  wire logic [31:0] q_in,
  output logic      [15:0] root
);
  localparam int STEPS = 16;

  logic [33:0] rem [0:STEPS];
  logic [33:0] res [0:STEPS];

  assign rem[0] = {2'b00, q_in};
  assign res[0] = '0;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [33:0] BIT = 34'(1) << (30 - 2 * k);
    logic [33:0] trial;
    assign trial = res[k] + BIT;
    always_ff @(posedge clk) begin
      if (ce) begin
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          res[k+1] <= (res[k] >> 1) + BIT;
        end else begin
          rem[k+1] <= rem[k];
          res[k+1] <= res[k] >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      root <= 16'(res[STEPS] + ((rem[STEPS] > res[STEPS]) ? 34'd1 : 34'd0));
    end
  end
endmodule
`default_nettype wire

/* rtl/core/tcch_cordic.sv */
// Pipelined vectoring CORDIC giving atan2(y, x) as a 32-bit binary angle.
`default_nettype none
module tcch_cordic #(
  parameter int W    = 20,
  parameter int ITER = 16
) (
  input  wire logic                clk,
  input  wire logic                ce,
  input  wire logic signed [W-1:0] y_in,
  input  wire logic signed [W-1:0] x_in,
  output logic             [31:0]  angle
);
  localparam int N = (ITER > tcch_pkg::TABLE_LEN) ? tcch_pkg::TABLE_LEN : ITER;

  logic signed [W-1:0] xs [0:N];
  logic signed [W-1:0] ys [0:N];
  logic        [31:0]  zs [0:N];
  logic                hold [0:N];

  // A vector on the x axis keeps its starting angle through all stages.
  always_ff @(posedge clk) begin
    if (ce) begin
      hold[0] <= (y_in == '0);
      if (x_in < 0) begin
        xs[0] <= -x_in;
        ys[0] <= -y_in;
        zs[0] <= tcch_pkg::HALF_TURN;
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic [31:0] ATN = tcch_pkg::atan_entry(5'(i));
    always_ff @(posedge clk) begin
      if (ce) begin
        hold[i+1] <= hold[i];
        if (hold[i]) begin
          xs[i+1] <= xs[i];
          ys[i+1] <= ys[i];
          zs[i+1] <= zs[i];
        end else if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATN;
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATN;
        end
      end
    end
  end

  assign angle = zs[N];
endmodule
`default_nettype wire

/* rtl/core/tilt_compensated_compass_heading.sv */
// Top level of the tilt-compensated compass: heading, pitch and roll per sample set.
`default_nettype none
// Each request on the slave side carries one accelerometer and one magnetometer
// sample set; each request on the master side carries its heading in centidegrees
// (0 to 35999), pitch and roll in signed centidegrees, and a degenerate flag that
// is set, with the heading forced to zero, when East or the acceleration vector is
// zero. The block is a pipeline that takes one request per cycle unless the master
// side stalls, and returns results in order; its depth is set by the square root of
// |a|^2 followed by the heading CORDIC, one stage per iteration. The whole pipeline
// advances together whenever the output register is empty or being taken, so a stall
// on the master side holds every stage in place
// and drops s_tready. The magnetometer calibration registers are written through
// the cfg port, which is ready whenever reset is low; they should be changed only
// while idle. Neither port takes requests while reset is high.
module tilt_compensated_compass_heading #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // Sample requests.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // From bit 0: accel_x, accel_y, accel_z, mag_x, mag_y, mag_z.
  input  wire logic [95:0] s_tdata,
  // Result requests.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // From bit 0: heading_cdeg, pitch_cdeg, roll_cdeg.
  output logic [47:0]      m_tdata,
  // Bit 0: degenerate.
  output logic             m_tuser
);
  localparam int N   = (ANGLE_ITERATIONS > tcch_pkg::TABLE_LEN) ?
                       tcch_pkg::TABLE_LEN : ANGLE_ITERATIONS;
  localparam int LAT = 24 + N;

  logic            ce;
  logic [LAT-1:0]  vld;
  tcch_pkg::axes_t mag_min, mag_max, accel_in, mag_in, accel1, accel3;
  logic signed [34:0] ex3, ey3, ez3;
  logic        [31:0] asq3;

  assign ce        = ~vld[LAT-1] | m_tready;
  assign s_tready  = ce & ~rst;
  assign m_tvalid  = vld[LAT-1];
  assign cfg_ready = ~rst;

  assign accel_in = '{x: s_tdata[15:0],  y: s_tdata[31:16], z: s_tdata[47:32]};
  assign mag_in   = '{x: s_tdata[63:48], y: s_tdata[79:64], z: s_tdata[95:80]};

  // Calibration registers; indexes beyond the last register are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      mag_min <= '{x: -16'sd1653, y: -16'sd1792, z: -16'sd1480};
      mag_max <= '{x: 16'sd2259, y: 16'sd2170, z: 16'sd2175};
    end else if (cfg_valid) begin
      case (cfg_index)
        tcch_pkg::REG_MIN_X: mag_min.x <= cfg_data;
        tcch_pkg::REG_MIN_Y: mag_min.y <= cfg_data;
        tcch_pkg::REG_MIN_Z: mag_min.z <= cfg_data;
        tcch_pkg::REG_MAX_X: mag_max.x <= cfg_data;
        tcch_pkg::REG_MAX_Y: mag_max.y <= cfg_data;
        tcch_pkg::REG_MAX_Z: mag_max.z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // Stages 1 to 3: corrected field, East = m' x a and |a|^2.
  tcch_front u_front (
    .clk(clk), .ce(ce), .accel(accel_in), .mag(mag_in),
    .mag_min(mag_min), .mag_max(mag_max), .accel1(accel1), .accel3(accel3),
    .ex3(ex3), .ey3(ey3), .ez3(ez3), .asq3(asq3)
  );

  // Stages 4 and 5: North z component and the degenerate test.
  logic signed [50:0] axey4, ayex4;
  logic signed [51:0] nz5, nz20;
  logic               degen4, degen_d;
  always_ff @(posedge clk) begin
    if (ce) begin
      axey4  <= accel3.x * ey3;
      ayex4  <= accel3.y * ex3;
      degen4 <= ((ex3 == '0) && (ey3 == '0) && (ez3 == '0)) || (asq3 == '0);
      nz5    <= {axey4[50], axey4} - {ayex4[50], ayex4};
    end
  end

  // |a| rounded to nearest, ready at the same stage as the delayed Nz and Ez.
  logic        [15:0] amag;
  logic signed [34:0] ez20;
  tcch_sqrt u_sqrt (.clk(clk), .ce(ce), .q_in(asq3), .root(amag));
  tcch_delay #(.W(52), .DEPTH(15)) u_dly_nz (.clk(clk), .ce(ce), .d(nz5), .q(nz20));
  tcch_delay #(.W(35), .DEPTH(17)) u_dly_ez (.clk(clk), .ce(ce), .d(ez3), .q(ez20));
  tcch_delay #(.W(1), .DEPTH(19 + N)) u_dly_dg (
    .clk(clk), .ce(ce), .d(degen4), .q(degen_d)
  );

  // Ez * |a| against Nz gives the heading without normalizing East.
  logic signed [51:0] ezam21;
  logic signed [51:0] nz21;
  always_ff @(posedge clk) begin
    if (ce) begin
      ezam21 <= ez20 * $signed({1'b0, amag});
      nz21   <= nz20;
    end
  end

  logic [31:0] z_head;
  tcch_cordic #(.W(54), .ITER(N)) u_cordic_head (
    .clk(clk), .ce(ce),
    .y_in({{2{ezam21[51]}}, ezam21}), .x_in({{2{nz21[51]}}, nz21}), .angle(z_head)
  );

  // Binary angle to centidegrees, rounded, with a full turn wrapping to zero.
  logic [47:0] head_prod;
  logic [48:0] head_sum;
  logic [16:0] head_c;
  logic [15:0] heading;
  logic        degen_o;
  assign head_sum = {1'b0, head_prod} + 49'(tcch_pkg::HALF_TURN);
  assign head_c   = head_sum[48:32];
  always_ff @(posedge clk) begin
    if (ce) begin
      head_prod <= z_head * tcch_pkg::CDEG_TURN;
      degen_o   <= degen_d;
      if (degen_d || head_c >= 17'(tcch_pkg::CDEG_TURN)) begin
        heading <= '0;
      end else begin
        heading <= head_c[15:0];
      end
    end
  end

  // Pitch and roll straight from the registered acceleration.
  logic [31:0] z_pitch, z_roll;
  tcch_cordic #(.W(20), .ITER(N)) u_cordic_pitch (
    .clk(clk), .ce(ce),
    .y_in({{4{accel1.z[15]}}, accel1.z}), .x_in({{4{accel1.x[15]}}, accel1.x}),
    .angle(z_pitch)
  );
  tcch_cordic #(.W(20), .ITER(N)) u_cordic_roll (
    .clk(clk), .ce(ce),
    .y_in({{4{accel1.y[15]}}, accel1.y}), .x_in({{4{accel1.x[15]}}, accel1.x}),
    .angle(z_roll)
  );

  // Signed conversion: the half turn reads as +180 degrees, rounding half away
  // from zero on the magnitude.
  logic [48:0] p_prod, r_prod;
  logic        p_neg, r_neg;
  logic [15:0] pitch_c, roll_c, pitch_o, roll_o;
  logic [49:0] p_sum, r_sum;

  function automatic logic [32:0] angle_mag(input logic [31:0] z);
    return (z > tcch_pkg::HALF_TURN) ? (33'h1_0000_0000 - {1'b0, z}) : {1'b0, z};
  endfunction

  assign p_sum = {1'b0, p_prod} + 50'(tcch_pkg::HALF_TURN);
  assign r_sum = {1'b0, r_prod} + 50'(tcch_pkg::HALF_TURN);

  always_ff @(posedge clk) begin
    if (ce) begin
      p_prod  <= angle_mag(z_pitch) * tcch_pkg::CDEG_TURN;
      r_prod  <= angle_mag(z_roll) * tcch_pkg::CDEG_TURN;
      p_neg   <= z_pitch > tcch_pkg::HALF_TURN;
      r_neg   <= z_roll > tcch_pkg::HALF_TURN;
      pitch_c <= p_neg ? 16'(-p_sum[47:32]) : p_sum[47:32];
      roll_c  <= r_neg ? 16'(-r_sum[47:32]) : r_sum[47:32];
    end
  end

  tcch_delay #(.W(16), .DEPTH(20)) u_dly_pitch (
    .clk(clk), .ce(ce), .d(pitch_c), .q(pitch_o)
  );
  tcch_delay #(.W(16), .DEPTH(20)) u_dly_roll (
    .clk(clk), .ce(ce), .d(roll_c), .q(roll_o)
  );

  assign m_tdata = {roll_o, pitch_o, heading};
  assign m_tuser = degen_o;
endmodule
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench of the tilt-compensated compass heading block.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  // Codes that no register answers to; writes there must leave the calibration alone.
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int LATENCY = 24 + 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] heading;
    logic [15:0] pitch;
    logic [15:0] roll;
    logic degen;
  } attitude_t;

  typedef struct {
    tcch_pkg::axes_t accel;
    tcch_pkg::axes_t mag;
    bit typed;
    attitude_t want;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [95:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic m_tuser;

  // Local copy of the calibration registers, updated as writes are accepted.
  logic signed [15:0] cal_min [3];
  logic signed [15:0] cal_max [3];

  attitude_t attitude_q[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int take_idle_pct = 0;

  tilt_compensated_compass_heading u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Vectoring CORDIC: binary angle of (x, y), a full turn being 2^32.
  function automatic logic [31:0] bin_angle(input longint y, input longint x);
    logic [31:0] z;
    longint dx, dy;
    z = '0;
    if (y == 0) return (x < 0) ? tcch_pkg::HALF_TURN : 32'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = tcch_pkg::HALF_TURN;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += tcch_pkg::atan_entry(i[4:0]);
      end else begin
        x -= dx;
        y += dy;
        z -= tcch_pkg::atan_entry(i[4:0]);
      end
    end
    return z;
  endfunction

  // Integer square root rounded to nearest.
  function automatic longint unsigned sqrt_nearest(input longint unsigned q);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > q) b >>= 2;
    while (b != 0) begin
      if (q >= r + b) begin
        q -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (q > r) r++;
    return r;
  endfunction

  // Binary angle to signed centidegrees, half away from zero; exactly half a turn is +180.
  function automatic logic [15:0] angle_cdeg(input logic [31:0] z);
    logic neg;
    longint unsigned mag, c;
    neg = z > tcch_pkg::HALF_TURN;
    mag = neg ? (64'd1 << 32) - z : {32'd0, z};
    c = (mag * 36000 + {32'd0, tcch_pkg::HALF_TURN}) >> 32;
    return neg ? 16'(-c) : 16'(c);
  endfunction

  function automatic attitude_t predict_attitude(input tcch_pkg::axes_t a,
                                                 input tcch_pkg::axes_t m);
    attitude_t r;
    longint ax, ay, az, mx, my, mz, ex, ey, ez, nz, amag;
    longint unsigned asq, hdg;
    ax = a.x; ay = a.y; az = a.z;
    mx = 2 * longint'(m.x) - (longint'(cal_min[0]) + cal_max[0]);
    my = 2 * longint'(m.y) - (longint'(cal_min[1]) + cal_max[1]);
    mz = 2 * longint'(m.z) - (longint'(cal_min[2]) + cal_max[2]);
    ex = my * az - mz * ay;
    ey = mz * ax - mx * az;
    ez = mx * ay - my * ax;
    asq = ax * ax + ay * ay + az * az;
    r.heading = '0;
    r.degen = 1'b0;
    if ((ex == 0 && ey == 0 && ez == 0) || asq == 0) begin
      r.degen = 1'b1;
    end else begin
      amag = longint'(sqrt_nearest(asq));
      nz = ax * ey - ay * ex;
      hdg = ({32'd0, bin_angle(ez * amag, nz)} * 36000 + {32'd0, tcch_pkg::HALF_TURN}) >> 32;
      r.heading = (hdg >= 36000) ? 16'd0 : hdg[15:0];
    end
    r.pitch = angle_cdeg(bin_angle(az, ax));
    r.roll = angle_cdeg(bin_angle(ay, ax));
    return r;
  endfunction

  // Result side: random back-pressure and in-order comparison against the expectations.
  always @(posedge clk) begin
    attitude_t want;
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (attitude_q.size() == 0) begin
        $error("unexpected result request %h", m_tdata);
        errors++;
      end else begin
        want = attitude_q.pop_front();
        if (m_tdata[15:0] !== want.heading) begin
          $error("heading_cdeg expected %0d got %0d", want.heading, m_tdata[15:0]);
          errors++;
        end
        if (m_tdata[31:16] !== want.pitch) begin
          $error("pitch_cdeg expected %0d got %0d", $signed(want.pitch), $signed(m_tdata[31:16]));
          errors++;
        end
        if (m_tdata[47:32] !== want.roll) begin
          $error("roll_cdeg expected %0d got %0d", $signed(want.roll), $signed(m_tdata[47:32]));
          errors++;
        end
        if (m_tuser !== want.degen) begin
          $error("degenerate expected %0d got %0d", want.degen, m_tuser);
          errors++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= take_idle_pct);
  end

  // A hung handshake must not hang the run.
  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offers one sample request, after random idle cycles, and queues its expected result.
  task automatic send_sample(input tcch_pkg::axes_t acc, input tcch_pkg::axes_t mag,
                             input bit typed, input attitude_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {mag, acc};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    attitude_q.push_back(typed ? want : predict_attitude(acc, mag));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (attitude_q.size() != 0) @(posedge clk);
  endtask

  // Register writes happen only once the pipeline is empty.
  task automatic write_cal(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      tcch_pkg::REG_MIN_X: cal_min[0] = val;
      tcch_pkg::REG_MIN_Y: cal_min[1] = val;
      tcch_pkg::REG_MIN_Z: cal_min[2] = val;
      tcch_pkg::REG_MAX_X: cal_max[0] = val;
      tcch_pkg::REG_MAX_Y: cal_max[1] = val;
      tcch_pkg::REG_MAX_Z: cal_max[2] = val;
      default: ;
    endcase
  endtask

  task automatic load_cal(input logic [15:0] mn [3], input logic [15:0] mx [3]);
    wait_drained();
    repeat (LATENCY + 8) @(posedge clk);
    write_cal(tcch_pkg::REG_MIN_X, mn[0]);
    write_cal(tcch_pkg::REG_MIN_Y, mn[1]);
    write_cal(tcch_pkg::REG_MIN_Z, mn[2]);
    write_cal(tcch_pkg::REG_MAX_X, mx[0]);
    write_cal(tcch_pkg::REG_MAX_Y, mx[1]);
    write_cal(tcch_pkg::REG_MAX_Z, mx[2]);
    write_cal(REG_SPARE_LO, 16'($urandom()));
    write_cal(REG_SPARE_HI, 16'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  // Mostly full-range values, with a share of extremes and near-zero values.
  function automatic logic [15:0] pick_axis();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(6)) - 3);
      3: return 16'(int'($urandom_range(400)) - 200);
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    sample_row_t rows[$];
    attitude_t zero_att;
    attitude_t half_degen;
    tcch_pkg::axes_t acc, mag;
    logic [15:0] mn [3];
    logic [15:0] mx [3];

    cal_min[0] = -16'sd1653; cal_min[1] = -16'sd1792; cal_min[2] = -16'sd1480;
    cal_max[0] = 16'sd2259;  cal_max[1] = 16'sd2170;  cal_max[2] = 16'sd2175;
    zero_att = '{heading: 16'd0, pitch: 16'd0, roll: 16'd0, degen: 1'b1};
    // Accel pointing along -x with no magnetic signal: pitch and roll are +180.
    half_degen = '{heading: 16'd0, pitch: 16'd18000, roll: 16'd18000, degen: 1'b1};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows run against the reset calibration. A zero acceleration vector
    // is degenerate whatever the magnetometer says.
    rows.push_back('{'{16'd0, 16'd0, 16'd0}, '{16'd0, 16'd0, 16'd0}, 1'b1, zero_att});
    rows.push_back('{'{16'd0, 16'd0, 16'd0}, '{16'h7FFF, 16'h8000, 16'h7FFF}, 1'b1, zero_att});
    rows.push_back('{'{16'd0, 16'd0, 16'h7FFF}, '{16'd0, 16'd0, 16'd0}, 1'b0, zero_att});
    rows.push_back('{'{16'd0, 16'h7FFF, 16'd0}, '{16'd100, 16'd0, 16'd0}, 1'b0, zero_att});
    rows.push_back('{'{16'h8000, 16'd0, 16'd0}, '{16'd303, 16'd189, 16'd0}, 1'b0, zero_att});
    rows.push_back('{'{16'h7FFF, 16'd0, 16'd0}, '{16'd0, 16'h7FFF, 16'd0}, 1'b0, zero_att});
    rows.push_back('{'{16'hFFFF, 16'd0, 16'd0}, '{16'd5, 16'd5, 16'd5}, 1'b0, zero_att});
    rows.push_back('{'{16'd0, 16'd0, 16'h8000}, '{16'h8000, 16'h8000, 16'h8000}, 1'b0, zero_att});
    rows.push_back('{'{16'h8000, 16'h8000, 16'h8000}, '{16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0,
                     zero_att});
    rows.push_back('{'{16'h7FFF, 16'h7FFF, 16'h7FFF}, '{16'h8000, 16'h7FFF, 16'h8000}, 1'b0,
                     zero_att});
    rows.push_back('{'{16'd1, 16'd1, 16'd1}, '{16'd1, 16'hFFFF, 16'd1}, 1'b0, zero_att});
    rows.push_back('{'{16'h8000, 16'h7FFF, 16'd0}, '{16'd0, 16'd0, 16'h7FFF}, 1'b0, zero_att});
    rows.push_back('{'{16'd0, 16'h8000, 16'h8000}, '{16'h1234, 16'hEDCB, 16'd0}, 1'b0, zero_att});
    rows.push_back('{'{16'd16384, 16'd0, 16'd16384}, '{16'd2000, 16'd0, 16'd0}, 1'b0, zero_att});

    send_idle_pct = 28;
    take_idle_pct = 87;
    foreach (rows[i]) send_sample(rows[i].accel, rows[i].mag, rows[i].typed, rows[i].want);

    // With all calibration at zero, a zero magnetometer makes East vanish.
    mn = '{16'd0, 16'd0, 16'd0};
    mx = '{16'd0, 16'd0, 16'd0};
    load_cal(mn, mx);
    send_sample('{16'd0, 16'd0, 16'h8000}, '{16'd0, 16'd0, 16'd0}, 1'b1, half_degen);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin send_idle_pct = 28; take_idle_pct = 87; end
        1: begin send_idle_pct = 87; take_idle_pct = 28; end
        default: begin send_idle_pct = 0; take_idle_pct = 0; end
      endcase
      case (phase)
        0: ; // keep the all-zero calibration
        1: begin mn = '{16'h8000, 16'h8000, 16'h8000}; mx = '{16'h8000, 16'h8000, 16'h8000}; end
        2: begin mn = '{16'h7FFF, 16'h7FFF, 16'h7FFF}; mx = '{16'h7FFF, 16'h7FFF, 16'h7FFF}; end
        3: begin mn = '{16'h7FFF, 16'd100, 16'h0FFF}; mx = '{16'h8000, 16'hFF00, 16'hF000}; end
        4: begin mn = '{16'h8000, 16'h8000, 16'h8000}; mx = '{16'h7FFF, 16'h7FFF, 16'h7FFF}; end
        default: begin
          mn = '{16'(-1653), 16'(-1792), 16'(-1480)};
          mx = '{16'd2259, 16'd2170, 16'd2175};
        end
      endcase
      if (phase != 0) load_cal(mn, mx);
      for (int n = 0; n < 320; n++) begin
        // Hold off once until the pipeline has drained completely.
        if (phase == 1 && n == 100) wait_drained();
        acc = {pick_axis(), pick_axis(), pick_axis()};
        mag = {pick_axis(), pick_axis(), pick_axis()};
        // Now and then cancel the hard-iron offset, which makes East zero where min + max is even on every axis.
        if ($urandom_range(15) == 0) begin
          mag.x = 16'((longint'(cal_min[0]) + cal_max[0]) >>> 1);
          mag.y = 16'((longint'(cal_min[1]) + cal_max[1]) >>> 1);
          mag.z = 16'((longint'(cal_min[2]) + cal_max[2]) >>> 1);
        end
        send_sample(acc, mag, 1'b0, zero_att);
      end
    end

    s_tvalid <= 1'b0;
    while (attitude_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* tilt_compensated_compass_heading.f */
rtl/core/tcch_pkg.sv
rtl/core/tcch_delay.sv
rtl/core/tcch_front.sv
rtl/core/tcch_sqrt.sv
rtl/core/tcch_cordic.sv
rtl/core/tilt_compensated_compass_heading.sv
dv/testbench.sv
